/* hdl/clsr_pkg.sv */
package clsr_pkg;

	// Width of a generator state, a seed and an output value.
	localparam int ValW = 31;

	// Moduli of the two generators and their distance below 2^31.
	localparam logic [31:0] ModOne  = 32'd2147483563;
	localparam logic [31:0] ModTwo  = 32'd2147483399;
	localparam logic [7:0]  FoldOne = 8'd85;
	localparam logic [7:0]  FoldTwo = 8'd249;

	// Multipliers of the two generators.
	localparam logic [15:0] MulOne = 16'd40014;
	localparam logic [15:0] MulTwo = 16'd40692;

	// Output wrap span and the reset value of the second generator.
	localparam logic [ValW-1:0] WrapSpan    = 31'd2147483562;
	localparam logic [ValW-1:0] SecondReset = 31'd123456789;

	// Command action codes.
	localparam logic ActDraw   = 1'b0;
	localparam logic ActReseed = 1'b1;

	// Which generator the shared modular multiplier works for.
	typedef enum logic {
		GEN_ONE,
		GEN_TWO
	} gen_sel_t;

	// Sequencer states.
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_WARM_MUL,
		ST_WARM_RED,
		ST_DIV,
		ST_G1_MUL,
		ST_G1_RED,
		ST_G2_MUL,
		ST_G2_RED,
		ST_MERGE
	} state_t;

endpackage

/* hdl/clsr_cmd_if.sv */
interface clsr_cmd_if;
	logic                       valid;
	logic                       ready;
	logic                       action;
	logic [clsr_pkg::ValW-1:0]  seed_value;

	modport source (output valid, action, seed_value, input ready);
	modport sink (input valid, action, seed_value, output ready);
endinterface

/* hdl/clsr_rsp_if.sv */
interface clsr_rsp_if;
	logic                       valid;
	logic                       ready;
	logic [clsr_pkg::ValW-1:0]  random_value;

	modport source (output valid, random_value, input ready);
	modport sink (input valid, random_value, output ready);
endinterface

/* hdl/clsr_ram.sv */
module clsr_ram #(
	parameter int WIDTH = 31,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// One write port and one registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

/* hdl/clsr_modmul.sv */
module clsr_modmul (
	input  logic                      clk,
	input  logic [clsr_pkg::ValW-1:0] x,
	input  clsr_pkg::gen_sel_t        sel,
	output logic [clsr_pkg::ValW-1:0] res
);

	logic [46:0]              prod_s1;
	clsr_pkg::gen_sel_t       sel_s1;
	logic [15:0]              mul_k;
	logic [15:0]              hi;
	logic [23:0]              fold;
	logic [31:0]              sum;
	logic [31:0]              modulus;
	logic [7:0]               fold_k;

	// Multiply by the generator's multiplier into the product register.
	assign mul_k = (sel == clsr_pkg::GEN_TWO) ? clsr_pkg::MulTwo : clsr_pkg::MulOne;

	always_ff @(posedge clk) begin
		prod_s1 <= 47'(x) * 47'(mul_k);
		sel_s1  <= sel;
	end

	// Then fold the bits above 2^31 back in, since 2^31 is congruent to
	// the fold constant, then one conditional subtract of the modulus.
	always_comb begin
		fold_k  = (sel_s1 == clsr_pkg::GEN_TWO) ? clsr_pkg::FoldTwo : clsr_pkg::FoldOne;
		modulus = (sel_s1 == clsr_pkg::GEN_TWO) ? clsr_pkg::ModTwo : clsr_pkg::ModOne;
		hi      = prod_s1[46:31];
		fold    = 24'(hi) * 24'(fold_k);
		sum     = {1'b0, prod_s1[30:0]} + 32'(fold);
		if (sum >= modulus) begin
			res = 31'(sum - modulus);
		end else begin
			res = sum[30:0];
		end
	end

endmodule

/* hdl/combined_lcg_shuffle_rng.sv */
// Draw: the divider states form the slot index, then each generator takes a multiply and a reduce
// state in the shared modular multiplier, and the merge state refills the table and loads the output.
// A reseed first runs generator one through the warm-up states, which fill the table. Ready returns
// the cycle after the merge; the merge waits while the output register is full and not being read.
// Reset gives generator one = 1, generator two = 123456789, previous output 0 and a
// shuffle table that reads as all zero through per-entry valid bits.
module combined_lcg_shuffle_rng #(
	parameter int TABLE_DEPTH = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	clsr_cmd_if.sink          cmd,
	clsr_rsp_if.source        rsp
);

	localparam int AW  = $clog2(TABLE_DEPTH);
	localparam int RW  = $clog2(TABLE_DEPTH) + 2;
	localparam int PW  = clsr_pkg::ValW + RW;
	localparam int DSW = 1;
	localparam int CW  = $clog2(TABLE_DEPTH + 8);
	localparam logic [clsr_pkg::ValW-1:0] SlotDiv = 31'(1 + 2147483562 / TABLE_DEPTH);
	// Reciprocal of the slot divisor scaled by 2^31, rounded down.
	localparam logic [RW-1:0] Recip = RW'((longint'(1) << 31) / longint'(SlotDiv));

	clsr_pkg::state_t state_q, state_d;

	logic [clsr_pkg::ValW-1:0] gen1_q, gen2_q, prev_q;
	logic [CW-1:0]             cnt_q;
	logic [clsr_pkg::ValW-1:0] rem_q;
	logic [RW-1:0]             quo_q;
	logic [DSW-1:0]            dstep_q;
	logic [AW-1:0]             slot_q;
	logic [TABLE_DEPTH-1:0]    valid_q;
	logic                      out_valid_q;
	logic [clsr_pkg::ValW-1:0] out_value_q;

	logic                      accept;
	logic [clsr_pkg::ValW-1:0] seed_eff;
	logic                      warm_last;
	logic                      warm_write;
	logic                      merge_fire;
	logic                      div_load;
	logic [clsr_pkg::ValW-1:0] div_src;
	logic [PW-1:0]             est_prod;
	logic [RW-1:0]             quo_est;
	logic [PW-1:0]             back_prod;
	logic [clsr_pkg::ValW-1:0] rem_fix;
	logic [RW-1:0]             quo_fix;
	logic [AW-1:0]             slot_sat;

	logic [clsr_pkg::ValW-1:0] mm_x, mm_res;
	clsr_pkg::gen_sel_t        mm_sel;

	logic                      ram_we;
	logic [AW-1:0]             ram_waddr;
	logic [clsr_pkg::ValW-1:0] ram_wdata, ram_rdata;

	logic [clsr_pkg::ValW-1:0] tbl_val;
	logic signed [32:0]        diff;
	logic signed [32:0]        diff_adj;
	logic [clsr_pkg::ValW-1:0] new_val;

	clsr_modmul u_modmul (
		.clk (clk),
		.x   (mm_x),
		.sel (mm_sel),
		.res (mm_res)
	);

	clsr_ram #(
		.WIDTH (clsr_pkg::ValW),
		.DEPTH (TABLE_DEPTH)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (slot_q),
		.rdata (ram_rdata)
	);

	// Handshake and status terms.
	assign accept     = cmd.valid && cmd.ready;
	assign seed_eff   = (cmd.seed_value == '0) ? 31'd1 : cmd.seed_value;
	assign warm_last  = (cnt_q == '0);
	assign warm_write = (cnt_q < CW'(TABLE_DEPTH));
	assign merge_fire = (state_q == clsr_pkg::ST_MERGE) && (!out_valid_q || rsp.ready);
	assign div_load   = (accept && (cmd.action == clsr_pkg::ActDraw)) ||
	                    ((state_q == clsr_pkg::ST_WARM_RED) && warm_last);
	assign div_src    = (state_q == clsr_pkg::ST_WARM_RED) ? mm_res : prev_q;

	// Slot index by reciprocal multiplication. The divider first registers an estimate that is
	// at most one low, then corrects it against the divisor and saturates it.
	always_comb begin
		est_prod  = PW'(rem_q) * PW'(Recip);
		quo_est   = est_prod[PW-1:clsr_pkg::ValW];
		back_prod = PW'(quo_q) * PW'(SlotDiv);
		rem_fix   = rem_q - back_prod[clsr_pkg::ValW-1:0];
		quo_fix   = quo_q + RW'(rem_fix >= SlotDiv);
		if (quo_fix >= RW'(TABLE_DEPTH)) begin
			slot_sat = AW'(TABLE_DEPTH - 1);
		end else begin
			slot_sat = quo_fix[AW-1:0];
		end
	end

	// Output value: selected slot minus generator two, wrapped into range.
	always_comb begin
		tbl_val  = valid_q[slot_q] ? ram_rdata : '0;
		diff     = $signed({2'b00, tbl_val}) - $signed({2'b00, gen2_q});
		diff_adj = (diff < 33'sd1) ? diff + $signed({2'b00, clsr_pkg::WrapSpan}) : diff;
		new_val  = diff_adj[30:0];
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			clsr_pkg::ST_IDLE: begin
				if (accept) begin
					state_d = (cmd.action == clsr_pkg::ActReseed) ? clsr_pkg::ST_WARM_MUL
					                                             : clsr_pkg::ST_DIV;
				end
			end
			clsr_pkg::ST_WARM_MUL: state_d = clsr_pkg::ST_WARM_RED;
			clsr_pkg::ST_WARM_RED: begin
				state_d = warm_last ? clsr_pkg::ST_DIV : clsr_pkg::ST_WARM_MUL;
			end
			clsr_pkg::ST_DIV: begin
				if (dstep_q == '0) begin
					state_d = clsr_pkg::ST_G1_MUL;
				end
			end
			clsr_pkg::ST_G1_MUL: state_d = clsr_pkg::ST_G1_RED;
			clsr_pkg::ST_G1_RED: state_d = clsr_pkg::ST_G2_MUL;
			clsr_pkg::ST_G2_MUL: state_d = clsr_pkg::ST_G2_RED;
			clsr_pkg::ST_G2_RED: state_d = clsr_pkg::ST_MERGE;
			clsr_pkg::ST_MERGE: begin
				if (merge_fire) begin
					state_d = clsr_pkg::ST_IDLE;
				end
			end
			default: state_d = clsr_pkg::ST_IDLE;
		endcase
	end

	// Sequencer outputs: multiplier operand, table write port, ready.
	always_comb begin
		cmd.ready = 1'b0;
		mm_x      = gen1_q;
		mm_sel    = clsr_pkg::GEN_ONE;
		ram_we    = 1'b0;
		ram_waddr = slot_q;
		ram_wdata = gen1_q;
		unique case (state_q)
			clsr_pkg::ST_IDLE: cmd.ready = 1'b1;
			clsr_pkg::ST_WARM_RED: begin
				ram_we    = warm_write;
				ram_waddr = cnt_q[AW-1:0];
				ram_wdata = mm_res;
			end
			clsr_pkg::ST_G2_MUL: begin
				mm_x   = gen2_q;
				mm_sel = clsr_pkg::GEN_TWO;
			end
			clsr_pkg::ST_G2_RED: mm_sel = clsr_pkg::GEN_TWO;
			clsr_pkg::ST_MERGE: ram_we = merge_fire;
			default: begin
			end
		endcase
	end

	// State, generators, previous output, warm-up counter, divider phase and table valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= clsr_pkg::ST_IDLE;
			gen1_q  <= 31'd1;
			gen2_q  <= clsr_pkg::SecondReset;
			prev_q  <= '0;
			valid_q <= '0;
			cnt_q   <= '0;
			dstep_q <= '0;
		end else begin
			state_q <= state_d;
			if (accept && (cmd.action == clsr_pkg::ActReseed)) begin
				gen1_q <= seed_eff;
				gen2_q <= seed_eff;
				cnt_q  <= CW'(TABLE_DEPTH + 7);
			end
			if (state_q == clsr_pkg::ST_WARM_RED) begin
				gen1_q <= mm_res;
				if (warm_write) begin
					valid_q[cnt_q[AW-1:0]] <= 1'b1;
				end
				if (warm_last) begin
					prev_q <= mm_res;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
			if (div_load) begin
				dstep_q <= DSW'(1);
			end else if (state_q == clsr_pkg::ST_DIV) begin
				dstep_q <= dstep_q - 1'b1;
			end
			if (state_q == clsr_pkg::ST_G1_RED) begin
				gen1_q <= mm_res;
			end
			if (state_q == clsr_pkg::ST_G2_RED) begin
				gen2_q <= mm_res;
			end
			if (merge_fire) begin
				prev_q          <= new_val;
				valid_q[slot_q] <= 1'b1;
			end
		end
	end

	// Divider datapath registers.
	always_ff @(posedge clk) begin
		if (div_load) begin
			rem_q <= div_src;
		end else if (state_q == clsr_pkg::ST_DIV) begin
			if (dstep_q != '0) begin
				quo_q <= quo_est;
			end else begin
				slot_q <= slot_sat;
			end
		end
	end

	// Output register: holds a finished result until it is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (merge_fire) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (merge_fire) begin
			out_value_q <= new_val;
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.random_value = out_value_q;

endmodule

/* bench/clsr_checker.sv */
module clsr_checker #(
	parameter int TABLE_DEPTH = 32
) (
	input  logic clk,
	input  logic arst_n,
	clsr_cmd_if  cmd,
	clsr_rsp_if  rsp,
	output int   err_count,
	output int   pending
);
	timeunit 1ns;
	timeprecision 1ps;
	import clsr_pkg::*;

	localparam longint SlotDiv   = 1 + longint'(WrapSpan) / TABLE_DEPTH;
	localparam int     ShowLimit = 10;

	// Predicted generator state, kept in step with accepted command transactions.
	logic [ValW-1:0] gen_one;
	logic [ValW-1:0] gen_two;
	logic [ValW-1:0] last_value;
	logic [ValW-1:0] shuffle [TABLE_DEPTH];

	// Values still owed by the block, oldest first.
	logic [ValW-1:0] owed_values [$];
	logic [ValW-1:0] want;
	int              failures;

	// One step of a multiplicative generator, exact product reduced by the modulus.
	function automatic logic [ValW-1:0] mod_advance(input logic [ValW-1:0] x,
			input logic [15:0] mult, input logic [31:0] modulus);
		logic [63:0] prod;
		prod = 64'(x) * 64'(mult);
		return ValW'(prod % 64'(modulus));
	endfunction

	// Load both generators from the seed, then fill the table during warm-up.
	function automatic void reseed_state(input logic [ValW-1:0] seed);
		logic [ValW-1:0] start;
		start = (seed == '0) ? ValW'(1) : seed;
		gen_one = start;
		gen_two = start;
		for (int i = TABLE_DEPTH + 7; i >= 0; i--) begin
			gen_one = mod_advance(gen_one, MulOne, ModOne);
			if (i < TABLE_DEPTH) begin
				shuffle[i] = gen_one;
			end
		end
		last_value = shuffle[0];
	endfunction

	// Advance both generators, take the slot picked by the last value and refill it.
	function automatic logic [ValW-1:0] next_value();
		longint slot;
		longint diff;
		gen_one = mod_advance(gen_one, MulOne, ModOne);
		gen_two = mod_advance(gen_two, MulTwo, ModTwo);
		slot = longint'(last_value) / SlotDiv;
		if (slot >= TABLE_DEPTH) begin
			slot = TABLE_DEPTH - 1;
		end
		diff = longint'(shuffle[slot]) - longint'(gen_two);
		shuffle[slot] = gen_one;
		if (diff < 1) begin
			diff += longint'(WrapSpan);
		end
		last_value = diff[ValW-1:0];
		return last_value;
	endfunction

	// Count a failure; only the first few are printed in full.
	task automatic note_failure(input string what, input logic [ValW-1:0] exp_val,
			input logic [ValW-1:0] got_val);
		failures++;
		if (failures <= ShowLimit) begin
			$display("%0t clsr_checker: %s: expected %0d (0x%08h), got %0d (0x%08h)",
				$realtime, what, exp_val, exp_val, got_val, got_val);
		end
	endtask

	// Compare each response transaction with the oldest owed value, then predict
	// the value owed for each new command transaction.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gen_one = 31'd1;
			gen_two = SecondReset;
			last_value = '0;
			for (int i = 0; i < TABLE_DEPTH; i++) begin
				shuffle[i] = '0;
			end
			owed_values.delete();
			failures = 0;
			err_count <= 0;
			pending <= 0;
		end else begin
			if (rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
				if (owed_values.size() == 0) begin
					note_failure("response with nothing owed", '0, rsp.random_value);
				end else begin
					want = owed_values.pop_front();
					if (rsp.random_value !== want) begin
						note_failure("random_value mismatch", want, rsp.random_value);
					end
				end
			end
			if (cmd.valid === 1'b1 && cmd.ready === 1'b1) begin
				if (cmd.action == ActReseed) begin
					reseed_state(cmd.seed_value);
				end
				owed_values.push_back(next_value());
			end
			err_count <= failures;
			pending <= owed_values.size();
		end
	end

endmodule

/* bench/tb_combined_lcg_shuffle_rng.sv */
module tb_combined_lcg_shuffle_rng;
	timeunit 1ns;
	timeprecision 1ps;
	import clsr_pkg::*;

	localparam int   Depth     = 32;
	localparam int   RandItems = 1200;

	logic clk;
	logic arst_n;
	int   err_count;
	int   pending;
	int   burst_left;

	clsr_cmd_if cmd_ch ();
	clsr_rsp_if rsp_ch ();

	combined_lcg_shuffle_rng #(
		.TABLE_DEPTH(Depth)
	) DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_ch),
		.rsp    (rsp_ch)
	);

	clsr_checker #(
		.TABLE_DEPTH(Depth)
	) u_check (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd_ch),
		.rsp       (rsp_ch),
		.err_count (err_count),
		.pending   (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hard stop in case the block hangs.
	initial begin
		#5ms;
		$display("tb_combined_lcg_shuffle_rng: done, errors");
		$finish;
	end

	// Offer one command transaction and hold it until accepted. Bursts end with a
	// random gap, often none at all.
	task automatic offer(input logic act, input logic [ValW-1:0] seed);
		int gap;
		cmd_ch.valid <= 1'b1;
		cmd_ch.action <= act;
		cmd_ch.seed_value <= seed;
		do @(posedge clk); while (cmd_ch.ready !== 1'b1);
		burst_left--;
		if (burst_left <= 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				cmd_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	// Seeds lean on the edge values: zero, one, the two moduli, the first modulus less one, and all ones.
	function automatic logic [ValW-1:0] pick_seed();
		case ($urandom_range(0, 11))
			0: return '0;
			1: return ModOne[ValW-1:0];
			2: return ModTwo[ValW-1:0];
			3: return '1;
			4: return ValW'(1);
			5: return ModOne[ValW-1:0] - ValW'(1);
			default: return ValW'($urandom());
		endcase
	endfunction

	// Response side: segments of steady, random and sparse ready, with one long
	// hold-off early on so the block backs up into the command channel.
	initial begin
		int seg;
		int len;
		int mode;
		rsp_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		seg = 0;
		forever begin
			if (seg == 3) begin
				rsp_ch.ready <= 1'b0;
				repeat (400) @(posedge clk);
			end else begin
				mode = $urandom_range(0, 2);
				len = $urandom_range(10, 80);
				repeat (len) begin
					case (mode)
						0: rsp_ch.ready <= 1'b1;
						1: rsp_ch.ready <= ($urandom_range(0, 1) == 1);
						default: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
					endcase
					@(posedge clk);
				end
			end
			seg++;
		end
	end

	// Command stimulus and verdict.
	initial begin
		logic act;
		cmd_ch.valid = 1'b0;
		cmd_ch.action = ActDraw;
		cmd_ch.seed_value = '0;
		arst_n = 1'b0;
		burst_left = $urandom_range(1, 24);
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Draws straight from the reset state, before any reseed.
		offer(ActDraw, '1);
		offer(ActDraw, '0);
		offer(ActDraw, 31'h2AAAAAAA);
		// Zero seed behaves as a seed of one.
		offer(ActReseed, '0);
		offer(ActDraw, 31'h55555555);
		offer(ActReseed, ValW'(1));
		offer(ActDraw, '0);
		offer(ActReseed, '1);
		// A seed equal to the first modulus zeroes the first generator for good.
		offer(ActReseed, ModOne[ValW-1:0]);
		offer(ActDraw, '0);
		offer(ActDraw, '1);
		offer(ActDraw, '0);
		offer(ActReseed, ModTwo[ValW-1:0]);
		offer(ActDraw, '0);
		offer(ActReseed, ModOne[ValW-1:0] - ValW'(1));
		offer(ActReseed, 31'h55555555);
		offer(ActReseed, 31'h2AAAAAAA);
		offer(ActDraw, '1);
		offer(ActDraw, '0);

		// Random part: mostly draws, with reseeds starting fresh sequences.
		repeat (RandItems) begin
			act = ($urandom_range(0, 99) < 12) ? ActReseed : ActDraw;
			offer(act, pick_seed());
		end
		cmd_ch.valid <= 1'b0;
		// Let the checker count the last accepted transaction before draining.
		@(posedge clk);

		// Drain, then give the block time to show any stray response.
		while (pending != 0) @(posedge clk);
		repeat (120) @(posedge clk);
		if (err_count == 0 && pending == 0) begin
			$display("tb_combined_lcg_shuffle_rng: done, clean");
		end else begin
			$display("tb_combined_lcg_shuffle_rng: done, errors");
		end
		$finish;
	end

endmodule
